// ===== rtl/strongly_connected_components_core_assert.svh =====
// assertion helpers used by the scc datapath
`ifndef STRONGLY_CONNECTED_COMPONENTS_CORE_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SCC_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("scc assertion failed");

// condition in one cycle implies a condition in the next
`define SCC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scc assertion failed");

// condition implies a condition in the same cycle
`define SCC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scc assertion failed");

`endif

// ===== rtl/scc_pkg.sv =====
package scc_pkg;

  // sizes
  localparam int NODE_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int EDGE_W      = 13;
  localparam int EDGE_AW     = 12;
  localparam int STACK_AW    = 13;
  localparam int TAG_W       = 11;
  localparam int STEP_W      = 5;
  localparam int MAX_NODES   = 1024;
  localparam int MAX_EDGES   = 4096;
  localparam int STACK_DEPTH = MAX_NODES + MAX_EDGES;

  // opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // stack tags
  localparam logic [TAG_W-1:0] TAG_OPEN = 11'd0;
  localparam logic [TAG_W-1:0] TAG_FIN  = 11'd1;
  localparam logic [TAG_W-1:0] TAG_NONE = 11'd1024;

  // controller steps
  localparam logic [STEP_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [STEP_W-1:0] ST_LOAD    = 5'd1;
  localparam logic [STEP_W-1:0] ST_READ    = 5'd2;
  localparam logic [STEP_W-1:0] ST_CLEAR   = 5'd3;
  localparam logic [STEP_W-1:0] ST_R_CLR   = 5'd4;
  localparam logic [STEP_W-1:0] ST_CNT_A   = 5'd5;
  localparam logic [STEP_W-1:0] ST_CNT_B   = 5'd6;
  localparam logic [STEP_W-1:0] ST_CNT_C   = 5'd7;
  localparam logic [STEP_W-1:0] ST_PFX_A   = 5'd8;
  localparam logic [STEP_W-1:0] ST_PFX_B   = 5'd9;
  localparam logic [STEP_W-1:0] ST_SCO_A   = 5'd10;
  localparam logic [STEP_W-1:0] ST_SCO_B   = 5'd11;
  localparam logic [STEP_W-1:0] ST_SCO_C   = 5'd12;
  localparam logic [STEP_W-1:0] ST_SCI_A   = 5'd13;
  localparam logic [STEP_W-1:0] ST_SCI_B   = 5'd14;
  localparam logic [STEP_W-1:0] ST_SCI_C   = 5'd15;
  localparam logic [STEP_W-1:0] ST_P1_PUSH = 5'd16;
  localparam logic [STEP_W-1:0] ST_WK_POP  = 5'd17;
  localparam logic [STEP_W-1:0] ST_WK_TOP  = 5'd18;
  localparam logic [STEP_W-1:0] ST_WK_VIS  = 5'd19;
  localparam logic [STEP_W-1:0] ST_WK_LO   = 5'd20;
  localparam logic [STEP_W-1:0] ST_WK_HI   = 5'd21;
  localparam logic [STEP_W-1:0] ST_WK_NB   = 5'd22;
  localparam logic [STEP_W-1:0] ST_WK_NBW  = 5'd23;
  localparam logic [STEP_W-1:0] ST_P2_CLR  = 5'd24;
  localparam logic [STEP_W-1:0] ST_P2_PA   = 5'd25;
  localparam logic [STEP_W-1:0] ST_P2_PB   = 5'd26;
  localparam logic [STEP_W-1:0] ST_RUN_END = 5'd27;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] dest_node;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  component_label;
    logic [COUNT_W-1:0] component_count;
    logic               error_flag;
  } result_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              pass;
  } cmd_t;

  typedef struct packed {
    logic idx_eq_n;
    logic edge_end;
    logic edge_ok;
    logic pfx_end;
    logic sci_end;
    logic stack_empty;
    logic is_fin;
    logic seen;
    logic nb_end;
    logic fin_end;
  } status_t;

endpackage

// ===== rtl/scc_ctrl.sv =====
module scc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     opcode,
  input  scc_pkg::status_t status,
  output scc_pkg::cmd_t  cmd,
  output logic           busy
);
  import scc_pkg::*;

  logic [STEP_W-1:0] state;
  logic [STEP_W-1:0] state_next;
  logic              pass;
  logic              pass_next;

  // next step
  always_comb begin
    state_next = state;
    pass_next  = pass;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (opcode)
            OP_LOAD:  state_next = ST_LOAD;
            OP_RUN:   state_next = ST_R_CLR;
            OP_READ:  state_next = ST_READ;
            OP_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD, ST_READ, ST_CLEAR, ST_RUN_END: state_next = ST_IDLE;
      ST_R_CLR: if (status.idx_eq_n) state_next = ST_CNT_A;
      ST_CNT_A: state_next = status.edge_end ? ST_PFX_A : ST_CNT_B;
      ST_CNT_B: state_next = status.edge_ok ? ST_CNT_C : ST_CNT_A;
      ST_CNT_C: state_next = ST_CNT_A;
      ST_PFX_A: state_next = status.pfx_end ? ST_SCO_A : ST_PFX_B;
      ST_PFX_B: state_next = ST_PFX_A;
      ST_SCO_A: state_next = status.edge_end ? ST_SCI_A : ST_SCO_B;
      ST_SCO_B: state_next = status.edge_ok ? ST_SCO_C : ST_SCO_A;
      ST_SCO_C: state_next = ST_SCO_A;
      ST_SCI_A: state_next = status.sci_end ? ST_P1_PUSH : ST_SCI_B;
      ST_SCI_B: state_next = ST_SCI_C;
      ST_SCI_C: state_next = ST_SCI_A;
      ST_P1_PUSH: begin
        pass_next = 1'b0;
        if (status.idx_eq_n) state_next = ST_WK_POP;
      end
      ST_WK_POP: begin
        if (status.stack_empty) state_next = pass ? ST_RUN_END : ST_P2_CLR;
        else state_next = ST_WK_TOP;
      end
      ST_WK_TOP: state_next = status.is_fin ? ST_WK_POP : ST_WK_VIS;
      ST_WK_VIS: state_next = status.seen ? ST_WK_POP : ST_WK_LO;
      ST_WK_LO:  state_next = ST_WK_HI;
      ST_WK_HI:  state_next = ST_WK_NB;
      ST_WK_NB:  state_next = status.nb_end ? ST_WK_POP : ST_WK_NBW;
      ST_WK_NBW: state_next = ST_WK_NB;
      ST_P2_CLR: begin
        if (status.idx_eq_n) begin
          state_next = ST_P2_PA;
          pass_next  = 1'b1;
        end
      end
      ST_P2_PA: state_next = status.fin_end ? ST_WK_POP : ST_P2_PB;
      ST_P2_PB: state_next = ST_P2_PA;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  assign cmd.step = state;
  assign cmd.pass = pass;
  assign busy     = (state != ST_IDLE);

endmodule

// ===== rtl/scc_datapath.sv =====
`include "strongly_connected_components_core_assert.svh"

module scc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  scc_pkg::item_t              item,
  input  logic [scc_pkg::COUNT_W-1:0] node_count,
  input  scc_pkg::cmd_t               cmd,
  output scc_pkg::status_t            status,
  output logic                        done,
  output scc_pkg::result_t            result
);
  import scc_pkg::*;

  // memories
  logic [2*NODE_W-1:0]      edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0]        oofs_mem [MAX_NODES+1];
  logic [EDGE_W-1:0]        iofs_mem [MAX_NODES+1];
  logic [EDGE_W-1:0]        ocur_mem [MAX_NODES];
  logic [EDGE_W-1:0]        icur_mem [MAX_NODES];
  logic [2*NODE_W-1:0]      oedg_mem [MAX_EDGES];
  logic [NODE_W-1:0]        isrc_mem [MAX_EDGES];
  logic                     vis_mem  [MAX_NODES];
  logic [NODE_W-1:0]        fin_mem  [MAX_NODES];
  logic [NODE_W+TAG_W-1:0]  stk_mem  [STACK_DEPTH];
  logic [NODE_W-1:0]        lbl_mem  [MAX_NODES];

  // ports of the memories
  logic                    edge_we;
  logic [EDGE_AW-1:0]      edge_waddr, edge_raddr;
  logic [2*NODE_W-1:0]     edge_wdata, edge_rd;
  logic                    oofs_we, iofs_we;
  logic [COUNT_W-1:0]      oofs_waddr, oofs_raddr, iofs_waddr, iofs_raddr;
  logic [EDGE_W-1:0]       oofs_wdata, oofs_rd, iofs_wdata, iofs_rd;
  logic                    ocur_we, icur_we;
  logic [NODE_W-1:0]       ocur_waddr, ocur_raddr, icur_waddr, icur_raddr;
  logic [EDGE_W-1:0]       ocur_wdata, ocur_rd, icur_wdata, icur_rd;
  logic                    oedg_we;
  logic [EDGE_AW-1:0]      oedg_waddr, oedg_raddr;
  logic [2*NODE_W-1:0]     oedg_wdata, oedg_rd;
  logic                    isrc_we;
  logic [EDGE_AW-1:0]      isrc_waddr, isrc_raddr;
  logic [NODE_W-1:0]       isrc_wdata, isrc_rd;
  logic                    vis_we, vis_wdata, vis_rd;
  logic [NODE_W-1:0]       vis_waddr, vis_raddr;
  logic                    fin_we;
  logic [NODE_W-1:0]       fin_waddr, fin_raddr, fin_wdata, fin_rd;
  logic                    stk_we;
  logic [STACK_AW-1:0]     stk_waddr, stk_raddr;
  logic [NODE_W+TAG_W-1:0] stk_wdata, stk_rd;
  logic                    lbl_we;
  logic [NODE_W-1:0]       lbl_waddr, lbl_raddr, lbl_wdata, lbl_rd;

  // registers
  item_t               item_r;
  logic [EDGE_W-1:0]   edge_total, idx, acc_o, acc_i, flt_total, hi;
  logic [STACK_AW-1:0] top;
  logic [COUNT_W-1:0]  fin, k, label_total, run_n;
  logic [NODE_W-1:0]   es, ed, v_r, lab_r;
  logic [TAG_W-1:0]    tag_r;
  logic                lvalid;

  // working values
  logic [COUNT_W-1:0]  n;
  logic [NODE_W-1:0]   e_s, e_d, sk_v;
  logic [TAG_W-1:0]    sk_tag;
  logic                e_ok, load_ok;
  logic [EDGE_W-1:0]   sum_o, sum_i;
  logic [NODE_W-1:0]   lab_new;

  // active node count, clamped
  always_comb begin
    if (node_count == '0) n = COUNT_W'(1);
    else if (node_count > COUNT_W'(MAX_NODES)) n = COUNT_W'(MAX_NODES);
    else n = node_count;
  end

  assign e_s     = edge_rd[2*NODE_W-1:NODE_W];
  assign e_d     = edge_rd[NODE_W-1:0];
  assign e_ok    = ({1'b0, e_s} < n) && ({1'b0, e_d} < n);
  assign sk_v    = stk_rd[NODE_W+TAG_W-1:TAG_W];
  assign sk_tag  = stk_rd[TAG_W-1:0];
  assign sum_o   = acc_o + oofs_rd;
  assign sum_i   = acc_i + iofs_rd;
  assign lab_new = (tag_r == TAG_NONE) ? k[NODE_W-1:0] : tag_r[NODE_W-1:0];
  assign load_ok = ({1'b0, item_r.source_node} < n) && ({1'b0, item_r.dest_node} < n)
                   && (edge_total < EDGE_W'(MAX_EDGES));

  // status to the controller
  always_comb begin
    status.idx_eq_n    = (idx == EDGE_W'(n));
    status.edge_end    = (idx == edge_total);
    status.edge_ok     = e_ok;
    status.pfx_end     = (idx > EDGE_W'(n));
    status.sci_end     = (idx == flt_total);
    status.stack_empty = (top == '0);
    status.is_fin      = !cmd.pass && (sk_tag == TAG_FIN);
    status.seen        = vis_rd;
    status.nb_end      = (idx == hi);
    status.fin_end     = (idx == EDGE_W'(fin));
  end

  // memory port selection per step
  always_comb begin
    edge_we = 1'b0; edge_waddr = edge_total[EDGE_AW-1:0];
    edge_wdata = {item_r.source_node, item_r.dest_node};
    edge_raddr = idx[EDGE_AW-1:0];
    oofs_we = 1'b0; oofs_waddr = idx[COUNT_W-1:0]; oofs_wdata = '0;
    oofs_raddr = idx[COUNT_W-1:0];
    iofs_we = 1'b0; iofs_waddr = idx[COUNT_W-1:0]; iofs_wdata = '0;
    iofs_raddr = idx[COUNT_W-1:0];
    ocur_we = 1'b0; ocur_waddr = idx[NODE_W-1:0]; ocur_wdata = sum_o; ocur_raddr = e_s;
    icur_we = 1'b0; icur_waddr = idx[NODE_W-1:0]; icur_wdata = sum_i;
    icur_raddr = oedg_rd[NODE_W-1:0];
    oedg_we = 1'b0; oedg_waddr = ocur_rd[EDGE_AW-1:0]; oedg_wdata = {es, ed};
    oedg_raddr = idx[EDGE_AW-1:0];
    isrc_we = 1'b0; isrc_waddr = icur_rd[EDGE_AW-1:0]; isrc_wdata = es;
    isrc_raddr = idx[EDGE_AW-1:0];
    vis_we = 1'b0; vis_waddr = idx[NODE_W-1:0]; vis_wdata = 1'b0; vis_raddr = sk_v;
    fin_we = 1'b0; fin_waddr = fin[NODE_W-1:0]; fin_wdata = sk_v;
    fin_raddr = idx[NODE_W-1:0];
    stk_we = 1'b0; stk_waddr = top; stk_wdata = '0; stk_raddr = top - STACK_AW'(1);
    lbl_we = 1'b0; lbl_waddr = v_r; lbl_wdata = lab_new; lbl_raddr = item_r.source_node;
    unique case (cmd.step)
      ST_IDLE: lbl_raddr = item.source_node;
      ST_LOAD: edge_we = load_ok;
      ST_R_CLR: begin
        oofs_we = 1'b1;
        iofs_we = 1'b1;
        vis_we  = (idx < EDGE_W'(n));
      end
      ST_CNT_B: begin
        oofs_raddr = COUNT_W'({1'b0, e_s}) + COUNT_W'(1);
        iofs_raddr = COUNT_W'({1'b0, e_d}) + COUNT_W'(1);
      end
      ST_CNT_C: begin
        oofs_we    = 1'b1;
        oofs_waddr = COUNT_W'({1'b0, es}) + COUNT_W'(1);
        oofs_wdata = oofs_rd + EDGE_W'(1);
        iofs_we    = 1'b1;
        iofs_waddr = COUNT_W'({1'b0, ed}) + COUNT_W'(1);
        iofs_wdata = iofs_rd + EDGE_W'(1);
      end
      ST_PFX_B: begin
        oofs_we    = 1'b1;
        oofs_wdata = sum_o;
        iofs_we    = 1'b1;
        iofs_wdata = sum_i;
        ocur_we    = (idx < EDGE_W'(n));
        icur_we    = (idx < EDGE_W'(n));
      end
      ST_SCO_C: begin
        oedg_we    = 1'b1;
        ocur_we    = 1'b1;
        ocur_waddr = es;
        ocur_wdata = ocur_rd + EDGE_W'(1);
      end
      ST_SCI_C: begin
        isrc_we    = 1'b1;
        icur_we    = 1'b1;
        icur_waddr = ed;
        icur_wdata = icur_rd + EDGE_W'(1);
      end
      ST_P1_PUSH: begin
        stk_we    = !status.idx_eq_n;
        stk_waddr = idx;
        stk_wdata = {idx[NODE_W-1:0], TAG_OPEN};
      end
      ST_WK_TOP: fin_we = status.is_fin;
      ST_WK_VIS: begin
        vis_raddr  = v_r;
        oofs_raddr = COUNT_W'({1'b0, v_r});
        iofs_raddr = COUNT_W'({1'b0, v_r});
        if (!vis_rd) begin
          vis_we    = 1'b1;
          vis_waddr = v_r;
          vis_wdata = 1'b1;
          if (!cmd.pass) begin
            stk_we    = 1'b1;
            stk_wdata = {v_r, TAG_FIN};
          end else begin
            lbl_we = 1'b1;
          end
        end
      end
      ST_WK_LO: begin
        oofs_raddr = COUNT_W'({1'b0, v_r}) + COUNT_W'(1);
        iofs_raddr = COUNT_W'({1'b0, v_r}) + COUNT_W'(1);
      end
      ST_WK_NBW: begin
        stk_we    = 1'b1;
        stk_wdata = cmd.pass ? {isrc_rd, {1'b0, lab_r}} : {oedg_rd[NODE_W-1:0], TAG_OPEN};
      end
      ST_P2_CLR: vis_we = !status.idx_eq_n;
      ST_P2_PB: begin
        stk_we    = 1'b1;
        stk_waddr = idx;
        stk_wdata = {fin_rd, TAG_NONE};
      end
      default: ;
    endcase
  end

  // memory arrays, registered reads
  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rd <= edge_mem[edge_raddr];
    if (oofs_we) oofs_mem[oofs_waddr] <= oofs_wdata;
    oofs_rd <= oofs_mem[oofs_raddr];
    if (iofs_we) iofs_mem[iofs_waddr] <= iofs_wdata;
    iofs_rd <= iofs_mem[iofs_raddr];
    if (ocur_we) ocur_mem[ocur_waddr] <= ocur_wdata;
    ocur_rd <= ocur_mem[ocur_raddr];
    if (icur_we) icur_mem[icur_waddr] <= icur_wdata;
    icur_rd <= icur_mem[icur_raddr];
    if (oedg_we) oedg_mem[oedg_waddr] <= oedg_wdata;
    oedg_rd <= oedg_mem[oedg_raddr];
    if (isrc_we) isrc_mem[isrc_waddr] <= isrc_wdata;
    isrc_rd <= isrc_mem[isrc_raddr];
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_rd <= vis_mem[vis_raddr];
    if (fin_we) fin_mem[fin_waddr] <= fin_wdata;
    fin_rd <= fin_mem[fin_raddr];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd <= stk_mem[stk_raddr];
    if (lbl_we) lbl_mem[lbl_waddr] <= lbl_wdata;
    lbl_rd <= lbl_mem[lbl_raddr];
  end

  // counters and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total  <= '0;
      label_total <= '0;
      lvalid      <= 1'b0;
      run_n       <= '0;
      top         <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (cmd.step)
        ST_IDLE: begin
          if (start) item_r <= item;
          idx <= '0;
        end
        ST_LOAD: begin
          if (load_ok) edge_total <= edge_total + EDGE_W'(1);
          done <= 1'b1;
          result.component_label <= '0;
          result.component_count <= label_total;
          result.error_flag      <= !load_ok;
        end
        ST_READ: begin
          done <= 1'b1;
          result.component_label <= (lvalid && ({1'b0, item_r.source_node} < run_n)
                                     && ({1'b0, item_r.source_node} < n))
                                    ? lbl_rd : '0;
          result.component_count <= label_total;
          result.error_flag      <= !({1'b0, item_r.source_node} < n);
        end
        ST_CLEAR: begin
          edge_total  <= '0;
          label_total <= '0;
          lvalid      <= 1'b0;
          done        <= 1'b1;
          result.component_label <= '0;
          result.component_count <= '0;
          result.error_flag      <= 1'b0;
        end
        ST_R_CLR: idx <= status.idx_eq_n ? '0 : idx + EDGE_W'(1);
        ST_CNT_A: begin
          if (status.edge_end) begin
            idx   <= '0;
            acc_o <= '0;
            acc_i <= '0;
          end
        end
        ST_CNT_B: begin
          es <= e_s;
          ed <= e_d;
          if (!e_ok) idx <= idx + EDGE_W'(1);
        end
        ST_CNT_C: idx <= idx + EDGE_W'(1);
        ST_PFX_A: begin
          if (status.pfx_end) begin
            idx       <= '0;
            flt_total <= acc_o;
          end
        end
        ST_PFX_B: begin
          acc_o <= sum_o;
          acc_i <= sum_i;
          idx   <= idx + EDGE_W'(1);
        end
        ST_SCO_A: if (status.edge_end) idx <= '0;
        ST_SCO_B: begin
          es <= e_s;
          ed <= e_d;
          if (!e_ok) idx <= idx + EDGE_W'(1);
        end
        ST_SCO_C: idx <= idx + EDGE_W'(1);
        ST_SCI_A: if (status.sci_end) idx <= '0;
        ST_SCI_B: begin
          es <= oedg_rd[2*NODE_W-1:NODE_W];
          ed <= oedg_rd[NODE_W-1:0];
        end
        ST_SCI_C: idx <= idx + EDGE_W'(1);
        ST_P1_PUSH: begin
          if (status.idx_eq_n) begin
            top <= STACK_AW'(n);
            fin <= '0;
            k   <= '0;
          end else begin
            idx <= idx + EDGE_W'(1);
          end
        end
        ST_WK_POP: begin
          if (!status.stack_empty) top <= top - STACK_AW'(1);
          else idx <= '0;
        end
        ST_WK_TOP: begin
          v_r   <= sk_v;
          tag_r <= sk_tag;
          if (status.is_fin) fin <= fin + COUNT_W'(1);
        end
        ST_WK_VIS: begin
          if (!vis_rd) begin
            if (!cmd.pass) top <= top + STACK_AW'(1);
            else begin
              lab_r <= lab_new;
              if (tag_r == TAG_NONE) k <= k + COUNT_W'(1);
            end
          end
        end
        ST_WK_LO: idx <= cmd.pass ? iofs_rd : oofs_rd;
        ST_WK_HI: hi  <= cmd.pass ? iofs_rd : oofs_rd;
        ST_WK_NBW: begin
          top <= top + STACK_AW'(1);
          idx <= idx + EDGE_W'(1);
        end
        ST_P2_CLR: idx <= status.idx_eq_n ? '0 : idx + EDGE_W'(1);
        ST_P2_PA: if (status.fin_end) top <= STACK_AW'(fin);
        ST_P2_PB: idx <= idx + EDGE_W'(1);
        ST_RUN_END: begin
          label_total <= k;
          lvalid      <= 1'b1;
          run_n       <= n;
          done        <= 1'b1;
          result.component_label <= '0;
          result.component_count <= k;
          result.error_flag      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // checks
  `SCC_ASSERT_ALWAYS(a_stack_bound, top <= STACK_AW'(STACK_DEPTH))
  `SCC_ASSERT_ALWAYS(a_edge_bound, edge_total <= EDGE_W'(MAX_EDGES))
  `SCC_ASSERT_NEXT(a_single_strobe, done, !done)
  `SCC_ASSERT_SAME(a_nb_range, cmd.step == ST_WK_NB, idx <= hi)

endmodule

// ===== rtl/strongly_connected_components_core.sv =====
// strongly connected components engine (two-pass kosaraju, explicit stack)
// command channel: an item (opcode, source_node, dest_node) is taken at a
// clock edge with start high and busy low. opcodes: load edge, run, read
// label, clear graph. every item gives exactly one result word on result,
// marked by done for one cycle; the receiver cannot stall it.
// config channel: cfg_data is node_count, written when cfg_valid and
// cfg_ready are both high; cfg_ready is high whenever the engine is idle.
// load, read and clear each pass through a single controller step before done,
// and the next item can be accepted in the cycle done is shown.
// a run walks the edge store twice (count, scatter out) and the sorted
// out-edge table once (scatter in), sweeps the node tables five times, then in
// both passes pops the stack: a finish mark (first pass only) is recorded, a
// node already seen is dropped and a new node is marked and has its neighbours
// pushed; every memory has one read port with a registered read.
// reset: edge store empty, all labels read as zero, component count zero,
// node_count is 1. no memory clearing pass is needed after reset.
module strongly_connected_components_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  scc_pkg::item_t              item,
  output logic                        done,
  output scc_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [scc_pkg::COUNT_W-1:0] cfg_data
);
  import scc_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [COUNT_W-1:0] node_count;

  // node count register
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  scc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  scc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .node_count (node_count),
    .cmd        (cmd),
    .status     (status),
    .done       (done),
    .result     (result)
  );

endmodule

// ===== tb/tb_strongly_connected_components_core.sv =====
`timescale 1ns / 1ps

module tb_strongly_connected_components_core;
  import scc_pkg::*;

  localparam int STALL_LIMIT = 400000;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  strongly_connected_components_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // scoreboard: scc predictor plus queue of expected result words
  class scc_scoreboard;
    int unsigned nodes_cfg;
    int unsigned out_off[MAX_NODES+1];
    int unsigned out_tgt[$];
    int unsigned in_off[MAX_NODES+1];
    int unsigned in_src[MAX_EDGES];
    int unsigned cursor[MAX_NODES];
    bit          seen[MAX_NODES];
    int unsigned fin_list[MAX_NODES];
    int unsigned labels[MAX_NODES];
    int unsigned comp_total;
    int unsigned stk_node[STACK_DEPTH];
    int unsigned stk_tag[STACK_DEPTH];
    int unsigned stk_top;
    result_t     pending[$];
    int          errors;
    int          words_in;
    int          words_out;
    int          runs;

    function new();
      nodes_cfg = 1;
      comp_total = 0;
      stk_top = 0;
      errors = 0;
      words_in = 0;
      words_out = 0;
      runs = 0;
      foreach (out_off[i]) out_off[i] = 0;
      foreach (labels[i]) labels[i] = 0;
    endfunction

    function int unsigned live_nodes();
      if (nodes_cfg == 0) return 1;
      if (nodes_cfg > MAX_NODES) return MAX_NODES;
      return nodes_cfg;
    endfunction

    function void push_walk(int unsigned v, int unsigned tag);
      if (stk_top < STACK_DEPTH) begin
        stk_node[stk_top] = v;
        stk_tag[stk_top] = tag;
        stk_top++;
      end
    endfunction

    function bit add_edge(int unsigned s, int unsigned d, int unsigned n);
      int unsigned pos;
      if (s >= n || d >= n || out_tgt.size() >= MAX_EDGES) return 1'b1;
      pos = out_off[s+1];
      if (pos > out_tgt.size()) pos = out_tgt.size();
      out_tgt.insert(pos, d);
      for (int i = s + 1; i <= MAX_NODES; i++) out_off[i]++;
      return 1'b0;
    endfunction

    function void find_components(int unsigned n);
      int unsigned v, tag, fin, k, lab;
      fin = 0;
      k = 0;
      // incoming adjacency by stable counting sort on destination
      foreach (in_off[i]) in_off[i] = 0;
      for (int u = 0; u < n; u++)
        for (int i = out_off[u]; i < out_off[u+1] && i < MAX_EDGES; i++)
          if (out_tgt[i] < n) in_off[out_tgt[i]+1]++;
      for (int u = 1; u <= n; u++) in_off[u] += in_off[u-1];
      for (int u = 0; u < n; u++) cursor[u] = in_off[u];
      for (int u = 0; u < n; u++)
        for (int i = out_off[u]; i < out_off[u+1] && i < MAX_EDGES; i++) begin
          v = out_tgt[i];
          if (v < n && cursor[v] < MAX_EDGES) begin
            in_src[cursor[v]] = u;
            cursor[v]++;
          end
        end
      // first pass: finish order
      stk_top = 0;
      for (int i = 0; i < n; i++) push_walk(i, 0);
      foreach (seen[i]) seen[i] = 0;
      while (stk_top > 0) begin
        stk_top--;
        v = stk_node[stk_top];
        tag = stk_tag[stk_top];
        if (tag == 0) begin
          if (!seen[v]) begin
            seen[v] = 1;
            push_walk(v, 1);
            for (int i = out_off[v]; i < out_off[v+1] && i < MAX_EDGES; i++)
              if (out_tgt[i] < n) push_walk(out_tgt[i], 0);
          end
        end else if (fin < MAX_NODES) begin
          fin_list[fin] = v;
          fin++;
        end
      end
      // second pass: label over reversed edges
      stk_top = 0;
      for (int i = 0; i < fin; i++) push_walk(fin_list[i], 32'hFFFF_FFFF);
      foreach (seen[i]) seen[i] = 0;
      foreach (labels[i]) labels[i] = 0;
      while (stk_top > 0) begin
        stk_top--;
        v = stk_node[stk_top];
        tag = stk_tag[stk_top];
        if (!seen[v]) begin
          seen[v] = 1;
          if (tag == 32'hFFFF_FFFF) begin
            lab = k;
            k++;
          end else begin
            lab = tag;
          end
          labels[v] = lab;
          for (int i = in_off[v]; i < in_off[v+1] && i < MAX_EDGES; i++)
            push_walk(in_src[i], lab);
        end
      end
      comp_total = k;
      runs++;
    endfunction

    // accepted command word: work out its result
    function void note_item(item_t it);
      result_t r;
      int unsigned n;
      n = live_nodes();
      r = '0;
      words_in++;
      case (it.opcode)
        OP_LOAD: r.error_flag = add_edge(it.source_node, it.dest_node, n);
        OP_RUN: find_components(n);
        OP_READ: begin
          if (it.source_node < n) r.component_label = NODE_W'(labels[it.source_node]);
          else r.error_flag = 1'b1;
        end
        default: begin
          out_tgt.delete();
          foreach (out_off[i]) out_off[i] = 0;
          foreach (labels[i]) labels[i] = 0;
          comp_total = 0;
        end
      endcase
      r.component_count = comp_total[COUNT_W-1:0];
      pending.insert(pending.size(), r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch on result word %0d: %s got %0d expected %0d",
               words_out, what, got, want);
      errors++;
    endtask

    task check_result(result_t r);
      result_t want;
      if (pending.size() == 0) begin
        $display("result word %0d arrived with nothing expected", words_out);
        errors++;
      end else begin
        want = pending.pop_front();
        if (r.component_label !== want.component_label)
          report("component_label", r.component_label, want.component_label);
        if (r.component_count !== want.component_count)
          report("component_count", r.component_count, want.component_count);
        if (r.error_flag !== want.error_flag)
          report("error_flag", r.error_flag, want.error_flag);
      end
      words_out++;
    endtask
  endclass

  scc_scoreboard sb;
  bit quiet;
  int stall_cycles;
  int sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // watchdog on cycles with no word accepted
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("tb_strongly_connected_components_core: FAIL");
        $finish;
      end
    end
  end

  task send(logic [1:0] op, logic [NODE_W-1:0] s, logic [NODE_W-1:0] d);
    item_t it;
    it.opcode = op;
    it.source_node = s;
    it.dest_node = d;
    if (!quiet && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(it);
    sent++;
  endtask

  // let the block go idle, then write node_count
  task set_nodes(logic [COUNT_W-1:0] v);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    sb.nodes_cfg = v;
  endtask

  // one random graph: mostly sorted well-formed edges, some noise
  task random_graph(int unsigned n);
    int unsigned cnt;
    int unsigned s;
    send(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
    cnt = $urandom_range(0, 3 * n);
    s = 0;
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(99) < 8) begin
        send(OP_LOAD, NODE_W'($urandom), NODE_W'($urandom));
      end else begin
        if ($urandom_range(3) == 0 && s + 1 < n) s = $urandom_range(s, n - 1);
        send(OP_LOAD, NODE_W'(s), NODE_W'($urandom_range(0, n - 1)));
      end
    end
    if ($urandom_range(9) == 0)
      send(OP_READ, NODE_W'($urandom_range(0, n - 1)), NODE_W'($urandom));
    send(OP_RUN, NODE_W'($urandom), NODE_W'($urandom));
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(9) == 0) send(OP_READ, NODE_W'($urandom), NODE_W'($urandom));
      else send(OP_READ, NODE_W'($urandom_range(0, n - 1)), NODE_W'($urandom));
    end
  endtask

  initial begin
    int unsigned n;
    sb = new();
    quiet = 1'b0;
    sent = 0;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: one node after reset, reads before any run
    send(OP_READ, 0, 0);
    send(OP_READ, 10'd1023, 10'd1023);
    send(OP_LOAD, 0, 0);
    send(OP_LOAD, 0, 1);
    send(OP_RUN, 0, 0);
    send(OP_READ, 0, 0);

    // directed: small graph with components {0,1,2} and {4,5}, an unsorted load and an out-of-range load
    set_nodes(8);
    send(OP_LOAD, 0, 1);
    send(OP_LOAD, 1, 2);
    send(OP_LOAD, 2, 0);
    send(OP_LOAD, 4, 5);
    send(OP_LOAD, 5, 4);
    send(OP_LOAD, 1, 0);
    send(OP_LOAD, 3, 8);
    send(OP_RUN, 0, 0);
    for (int i = 0; i < 8; i++) send(OP_READ, NODE_W'(i), 0);
    send(OP_READ, 10'd1023, 0);

    // node count above the limit acts as the limit; then lowered to zero
    set_nodes(11'd2047);
    send(OP_LOAD, 10'd1023, 0);
    send(OP_LOAD, 0, 10'd1023);
    send(OP_RUN, 0, 0);
    send(OP_READ, 10'd1023, 0);
    set_nodes(0);
    send(OP_RUN, 0, 0);
    send(OP_READ, 0, 0);
    send(OP_CLEAR, 0, 0);
    send(OP_READ, 0, 0);

    // random graphs over several node counts, a quiet stretch in the middle
    for (int ph = 0; sent < 1450; ph++) begin
      quiet = (ph >= 6 && ph < 10);
      if (ph % 3 == 0) begin
        case ($urandom_range(3))
          0: n = 2;
          1: n = $urandom_range(1, 1024);
          default: n = $urandom_range(2, 40);
        endcase
        set_nodes(COUNT_W'(n));
      end
      n = sb.live_nodes();
      if (n > 64) n = 64;
      random_graph(n);
      if ($urandom_range(9) == 0) set_nodes(COUNT_W'($urandom_range(1, 2047)));
      if ($urandom_range(4) == 0)
        send(2'($urandom), NODE_W'($urandom), NODE_W'($urandom));
    end

    // largest node count: a denser graph and a run over it
    quiet = 1'b1;
    set_nodes(11'd1024);
    send(OP_CLEAR, 0, 0);
    for (int i = 0; i < 320; i++) send(OP_LOAD, NODE_W'(i / 2), NODE_W'($urandom));
    send(OP_RUN, 0, 0);
    quiet = 1'b0;
    repeat (16) send(OP_READ, NODE_W'($urandom), NODE_W'($urandom));
    send(OP_CLEAR, 0, 0);

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d command words, %0d component runs, %0d result words",
             sent, sb.runs, sb.words_out);
    $display("node counts from zero to above the limit, unsorted and out of range loads");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_strongly_connected_components_core: PASS");
    end else begin
      $display("tb_strongly_connected_components_core: FAIL");
    end
    $finish;
  end

endmodule
